// File: rtl/eor_pkg.sv
// eor_pkg: types and constants shared by the extent overlay resolver.
// Used by eor_ctrl, eor_dp and extent_overlay_resolver; no dependencies.
package eor_pkg;

	localparam int OFS_W  = 48;
	localparam int LEN_W  = 32;
	localparam int ID_W   = 48;
	localparam int GEN_W  = 32;
	localparam int CS_W   = 33;
	localparam int CI_W   = 24;
	localparam int FL_W   = 48;
	localparam int XE_W   = 49;
	localparam int WB_W   = 57;
	localparam int WE_W   = 58;
	localparam int SRC_MW = 5;
	localparam int DATA_W = 64;
	localparam int ADDR_W = 5;

	localparam logic [1:0] REG_CHUNK_SIZE  = 2'd0;
	localparam logic [1:0] REG_CHUNK_INDEX = 2'd1;
	localparam logic [1:0] REG_FILE_LENGTH = 2'd2;

	// one interval of the window list
	typedef struct packed {
		logic [OFS_W-1:0]  b;
		logic [OFS_W-1:0]  e;
		logic              used;
		logic [SRC_MW-1:0] src;
	} ent_t;

	typedef struct packed {
		logic load;
		logic clr_job;
		logic win_mul;
		logic win_init;
		logic pass_start;
		logic rd;
		logic p0;
		logic p1;
		logic p2;
		logic pass_end;
		logic emit_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic i_done;
		logic free_zero;
		logic k_zero;
		logic overlap;
	} sts_t;

endpackage

// File: rtl/eor_ctrl.sv
// eor_ctrl: sequencer for load, window setup, carve passes and emission.
// Depends on eor_pkg; drives eor_dp through cmd_t, reads sts_t.
module eor_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last_extent,
	input  eor_pkg::sts_t sts,
	output eor_pkg::cmd_t cmd,
	output logic          busy
);
	import eor_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1;
	localparam logic [3:0] S_WIN  = 4'd2;
	localparam logic [3:0] S_WCHK = 4'd3;
	localparam logic [3:0] S_XSET = 4'd4;
	localparam logic [3:0] S_RD   = 4'd5;
	localparam logic [3:0] S_P0   = 4'd6;
	localparam logic [3:0] S_P1   = 4'd7;
	localparam logic [3:0] S_P2   = 4'd8;
	localparam logic [3:0] S_PEND = 4'd9;
	localparam logic [3:0] S_EST  = 4'd10;
	localparam logic [3:0] S_ERD  = 4'd11;
	localparam logic [3:0] S_EOUT = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_extent) state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.win_mul = 1'b1;
				state_d = S_WIN;
			end
			S_WIN: begin
				cmd.win_init = 1'b1;
				state_d = S_WCHK;
			end
			S_WCHK: begin
				state_d = (sts.free_zero || sts.cnt_zero) ? S_EST : S_XSET;
			end
			S_XSET: begin
				cmd.pass_start = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				if (sts.i_done) begin
					state_d = S_PEND;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_P0;
				end
			end
			S_P0: begin
				cmd.p0 = 1'b1;
				state_d = sts.overlap ? S_P1 : S_RD;
			end
			S_P1: begin
				cmd.p1 = 1'b1;
				state_d = S_P2;
			end
			S_P2: begin
				cmd.p2 = 1'b1;
				state_d = S_RD;
			end
			S_PEND: begin
				cmd.pass_end = 1'b1;
				state_d = (sts.free_zero || sts.k_zero) ? S_EST : S_XSET;
			end
			S_EST: begin
				cmd.emit_start = 1'b1;
				state_d = S_ERD;
			end
			S_ERD: begin
				if (sts.i_done) begin
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_EOUT;
				end
			end
			S_EOUT: begin
				cmd.emit = 1'b1;
				state_d = S_ERD;
			end
			S_DONE: begin
				cmd.clr_job = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_extent) |=> (state_q == S_MUL))
		else $error("resolve did not start");
	a_plain_load: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_extent) |=> !busy)
		else $error("plain load went busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> !busy)
		else $error("job end did not return to idle");

endmodule

// File: rtl/eor_dp.sv
// eor_dp: extent store, ping-pong interval list memory, carve and emit logic.
// Depends on eor_pkg; commanded by eor_ctrl.
module eor_dp #(
	parameter int MAX_EXTENTS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  eor_pkg::cmd_t             cmd,
	output eor_pkg::sts_t             sts,
	input  logic [eor_pkg::CS_W-1:0]  chunk_size,
	input  logic [eor_pkg::CI_W-1:0]  chunk_index,
	input  logic [eor_pkg::FL_W-1:0]  file_length,
	input  logic [eor_pkg::OFS_W-1:0] extent_offset,
	input  logic [eor_pkg::LEN_W-1:0] extent_length,
	input  logic [eor_pkg::ID_W-1:0]  source_id,
	input  logic [eor_pkg::GEN_W-1:0] generation,
	input  logic                      is_zero,
	output logic                      seg_valid,
	output logic [eor_pkg::OFS_W-1:0] seg_begin,
	output logic [eor_pkg::OFS_W-1:0] seg_end,
	output logic [eor_pkg::ID_W-1:0]  seg_source_id,
	output logic [eor_pkg::GEN_W-1:0] seg_generation,
	output logic [eor_pkg::OFS_W-1:0] seg_extent_offset,
	output logic [eor_pkg::LEN_W-1:0] seg_extent_length,
	output logic                      seg_zero,
	output logic                      overflow,
	output logic                      last_segment
);
	import eor_pkg::*;

	localparam int SRC_W  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
	localparam int LIST_D = 2 * MAX_EXTENTS + 1;
	localparam int LC_W   = $clog2(LIST_D + 1);
	localparam int LI_W   = $clog2(LIST_D);

	logic [OFS_W-1:0] st_ofs [MAX_EXTENTS];
	logic [LEN_W-1:0] st_len [MAX_EXTENTS];
	logic [ID_W-1:0]  st_id  [MAX_EXTENTS];
	logic [GEN_W-1:0] st_gen [MAX_EXTENTS];
	logic             st_zero[MAX_EXTENTS];

	ent_t mem_q [2][LIST_D];
	ent_t rdata_q;

	logic [CNT_W-1:0] cnt_q, cnt_m1;
	logic             ovf_q;
	logic [SRC_W-1:0] k_q;
	logic [LC_W-1:0]  i_q, olen_q, wlen_q, fcnt_q, ucnt_q, ecnt_q, ecnt_nx;
	logic             bank_q;
	logic [WB_W-1:0]  wb_q;
	logic [OFS_W-1:0] xb_q;
	logic [XE_W-1:0]  xe_q;
	logic             xz_q;

	logic [WE_W-1:0]  we_raw, we_min, we_m1;
	logic             win_ne;
	logic [XE_W-1:0]  ent_b, ent_e;
	logic             left_ex, right_ex, ovl;
	logic             wr_en;
	ent_t             wr_ent;
	logic [SRC_W-1:0] src_i;

	assign cnt_m1  = cnt_q - 1'b1;
	assign ecnt_nx = ecnt_q + 1'b1;
	assign src_i   = rdata_q.src[SRC_W-1:0];

	assign we_raw = {1'b0, wb_q} + WE_W'(chunk_size);
	assign we_min = (we_raw < WE_W'(file_length)) ? we_raw : WE_W'(file_length);
	assign we_m1  = we_min - 1'b1;
	assign win_ne = {1'b0, wb_q} < we_min;

	assign ent_b    = {1'b0, rdata_q.b};
	assign ent_e    = {1'b0, rdata_q.e};
	assign ovl      = !rdata_q.used && !xz_q && !(xe_q < ent_b) && !(XE_W'(xb_q) > ent_e);
	assign left_ex  = XE_W'(xb_q) > ent_b;
	assign right_ex = xe_q < ent_e;

	always_comb begin
		wr_en  = 1'b0;
		wr_ent = rdata_q;
		if (cmd.win_init) begin
			wr_en  = win_ne;
			wr_ent = '{b: wb_q[OFS_W-1:0], e: we_m1[OFS_W-1:0], used: 1'b0, src: '0};
		end else if (cmd.p0) begin
			if (ovl) begin
				wr_en  = left_ex;
				wr_ent = '{b: rdata_q.b, e: xb_q - 1'b1, used: 1'b0, src: '0};
			end else begin
				wr_en = 1'b1;
			end
		end else if (cmd.p1) begin
			wr_en  = 1'b1;
			wr_ent = '{b: left_ex ? xb_q : rdata_q.b,
				e: right_ex ? xe_q[OFS_W-1:0] : rdata_q.e,
				used: 1'b1, src: SRC_MW'(k_q)};
		end else if (cmd.p2) begin
			wr_en  = right_ex;
			wr_ent = '{b: xe_q[OFS_W-1:0] + 1'b1, e: rdata_q.e, used: 1'b0, src: '0};
		end
	end

	// storage and payload
	always_ff @(posedge clk) begin
		if (cmd.load && cnt_q < CNT_W'(MAX_EXTENTS)) begin
			st_ofs[cnt_q[SRC_W-1:0]]  <= extent_offset;
			st_len[cnt_q[SRC_W-1:0]]  <= extent_length;
			st_id[cnt_q[SRC_W-1:0]]   <= source_id;
			st_gen[cnt_q[SRC_W-1:0]]  <= generation;
			st_zero[cnt_q[SRC_W-1:0]] <= is_zero;
		end
		if (wr_en) begin
			if (cmd.win_init) mem_q[bank_q][0] <= wr_ent;
			else mem_q[!bank_q][wlen_q[LI_W-1:0]] <= wr_ent;
		end
		if (cmd.rd) rdata_q <= mem_q[bank_q][i_q[LI_W-1:0]];
		if (cmd.win_mul) wb_q <= WB_W'(chunk_size) * WB_W'(chunk_index);
		if (cmd.pass_start) begin
			xb_q <= st_ofs[k_q];
			xe_q <= XE_W'(st_ofs[k_q]) + XE_W'(st_len[k_q]) - 1'b1;
			xz_q <= (st_len[k_q] == '0);
		end
		if (cmd.emit && rdata_q.used) begin
			seg_begin         <= rdata_q.b;
			seg_end           <= rdata_q.e;
			seg_source_id     <= st_id[src_i];
			seg_generation    <= st_gen[src_i];
			seg_extent_offset <= st_ofs[src_i];
			seg_extent_length <= st_len[src_i];
			seg_zero          <= st_zero[src_i];
			overflow          <= ovf_q;
			last_segment      <= (ecnt_nx == ucnt_q);
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			k_q       <= '0;
			i_q       <= '0;
			olen_q    <= '0;
			wlen_q    <= '0;
			fcnt_q    <= '0;
			ucnt_q    <= '0;
			ecnt_q    <= '0;
			bank_q    <= 1'b0;
			seg_valid <= 1'b0;
		end else begin
			seg_valid <= cmd.emit && rdata_q.used;
			if (cmd.load) begin
				if (cnt_q < CNT_W'(MAX_EXTENTS)) cnt_q <= cnt_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.clr_job) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.win_init) begin
				olen_q <= LC_W'(win_ne);
				fcnt_q <= LC_W'(win_ne);
				ucnt_q <= '0;
				k_q    <= cnt_m1[SRC_W-1:0];
			end
			if (cmd.pass_start) begin
				i_q    <= '0;
				wlen_q <= '0;
				fcnt_q <= '0;
			end
			if (cmd.rd) i_q <= i_q + 1'b1;
			if (wr_en && !cmd.win_init) begin
				wlen_q <= wlen_q + 1'b1;
				if (!wr_ent.used) fcnt_q <= fcnt_q + 1'b1;
			end
			if (cmd.p1) ucnt_q <= ucnt_q + 1'b1;
			if (cmd.pass_end) begin
				bank_q <= !bank_q;
				olen_q <= wlen_q;
				k_q    <= k_q - 1'b1;
			end
			if (cmd.emit_start) begin
				i_q    <= '0;
				ecnt_q <= '0;
			end
			if (cmd.emit && rdata_q.used) ecnt_q <= ecnt_nx;
		end
	end

	assign sts.cnt_zero  = (cnt_q == '0);
	assign sts.i_done    = (i_q == olen_q);
	assign sts.free_zero = (fcnt_q == '0);
	assign sts.k_zero    = (k_q == '0);
	assign sts.overlap   = ovl;

	a_list_fits: assert property (@(posedge clk) disable iff (!arst_n)
		wlen_q <= LC_W'(LIST_D))
		else $error("interval list overran");
	a_free_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pass_end |-> (fcnt_q <= wlen_q))
		else $error("free count above list length");
	a_seg_order: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> (seg_begin <= seg_end))
		else $error("segment begin past end");

endmodule

// File: rtl/extent_overlay_resolver.sv
// extent_overlay_resolver: top level with APB register file, eor_ctrl and eor_dp.
// Depends on eor_pkg, eor_ctrl, eor_dp.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  extent    | start & !busy           | extent_offset .. is_zero, last_extent
//  segment   | seg_valid (one cycle)   | seg_begin .. seg_zero, overflow, last_segment
//  config    | psel & penable & pwrite | paddr (8-byte regs), pwdata, prdata
//
// A non-final word is stored and busy stays low.
// A final word runs a resolve: window setup (S_MUL, S_WIN, S_WCHK), then for each
// carved extent a pass (S_XSET, S_RD and S_P0 per list entry, S_P1 and S_P2 per
// entry it overlaps, S_PEND; list up to 2*MAX_EXTENTS+1 entries, one memory read
// port), then emission (S_EST, S_ERD and S_EOUT per list entry, S_DONE). Passes
// stop early once no window byte is free. Reset clears counters and state; stores
// need no clearing. Segments cannot be stalled: each is shown for one cycle.
module extent_overlay_resolver #(
	parameter int MAX_EXTENTS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [eor_pkg::OFS_W-1:0] extent_offset,
	input  logic [eor_pkg::LEN_W-1:0] extent_length,
	input  logic [eor_pkg::ID_W-1:0]  source_id,
	input  logic [eor_pkg::GEN_W-1:0] generation,
	input  logic                      is_zero,
	input  logic                      last_extent,
	output logic                      seg_valid,
	output logic [eor_pkg::OFS_W-1:0] seg_begin,
	output logic [eor_pkg::OFS_W-1:0] seg_end,
	output logic [eor_pkg::ID_W-1:0]  seg_source_id,
	output logic [eor_pkg::GEN_W-1:0] seg_generation,
	output logic [eor_pkg::OFS_W-1:0] seg_extent_offset,
	output logic [eor_pkg::LEN_W-1:0] seg_extent_length,
	output logic                      seg_zero,
	output logic                      overflow,
	output logic                      last_segment,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [eor_pkg::ADDR_W-1:0] paddr,
	input  logic [eor_pkg::DATA_W-1:0] pwdata,
	output logic [eor_pkg::DATA_W-1:0] prdata,
	output logic                      pready
);
	import eor_pkg::*;

	logic [CS_W-1:0] cs_q;
	logic [CI_W-1:0] ci_q;
	logic [FL_W-1:0] fl_q;
	logic [1:0]      reg_sel;
	cmd_t            cmd;
	sts_t            sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CS_W'(64'd67108864);
			ci_q <= '0;
			fl_q <= FL_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_CHUNK_SIZE:  cs_q <= pwdata[CS_W-1:0];
				REG_CHUNK_INDEX: ci_q <= pwdata[CI_W-1:0];
				REG_FILE_LENGTH: fl_q <= pwdata[FL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_CHUNK_SIZE:  prdata = DATA_W'(cs_q);
			REG_CHUNK_INDEX: prdata = DATA_W'(ci_q);
			REG_FILE_LENGTH: prdata = DATA_W'(fl_q);
			default:         prdata = '0;
		endcase
	end

	eor_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_extent (last_extent),
		.sts         (sts),
		.cmd         (cmd),
		.busy        (busy)
	);

	eor_dp #(
		.MAX_EXTENTS (MAX_EXTENTS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.chunk_size        (cs_q),
		.chunk_index       (ci_q),
		.file_length       (fl_q),
		.extent_offset     (extent_offset),
		.extent_length     (extent_length),
		.source_id         (source_id),
		.generation        (generation),
		.is_zero           (is_zero),
		.seg_valid         (seg_valid),
		.seg_begin         (seg_begin),
		.seg_end           (seg_end),
		.seg_source_id     (seg_source_id),
		.seg_generation    (seg_generation),
		.seg_extent_offset (seg_extent_offset),
		.seg_extent_length (seg_extent_length),
		.seg_zero          (seg_zero),
		.overflow          (overflow),
		.last_segment      (last_segment)
	);

endmodule
